### rtl/ndwd_pkg.sv
// ndwd_pkg: shared types and constants of the near-duplicate window detector.
// No dependencies; imported by the interfaces and every module.
`default_nettype none

package ndwd_pkg;

    // Field and register widths
    localparam int VALUE_W    = 32;
    localparam int WINDOW_K_W = 7;
    localparam int TOL_W      = 31;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 1;

    // Default window depth handed to the top level
    localparam int DEFAULT_WINDOW_DEPTH = 64;

    // Hit flags folded into the result per scan cycle
    localparam int SCAN_GROUP_LOG = 3;
    localparam int SCAN_GROUP     = 1 << SCAN_GROUP_LOG;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_K  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd1;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Per-cycle command to every window cell
    typedef struct packed
    {
        logic load;   // compare against new value, shift values by one cell
        logic scan;   // shift hit flags down by one group
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/ndwd_if.sv
// ndwd_in_if / ndwd_out_if: valid/ready channels of the window detector.
// Depends on ndwd_pkg for the payload widths.
`default_nettype none

interface ndwd_in_if import ndwd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      first;

    modport source (output valid, output value, output first, input ready);
    modport sink   (input valid, input value, input first, output ready);
endinterface

interface ndwd_out_if import ndwd_pkg::*; ();
    logic valid;
    logic ready;
    logic hit;
    logic found;

    modport source (output valid, output hit, output found, input ready);
    modport sink   (input valid, input hit, input found, output ready);
endinterface

`default_nettype wire

### rtl/ndwd_cell.sv
// ndwd_cell: one window slot; holds a value and its hit flag.
// Depends on ndwd_pkg; instantiated in a row by near_duplicate_window_detect.
`default_nettype none

module ndwd_cell import ndwd_pkg::*;
#(
    parameter int INDEX  = 0,
    parameter int SPAN_W = 7
)
(
    input  wire logic               clk,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [SPAN_W-1:0]  span,
    input  wire logic [VALUE_W-1:0] cmp_value,
    input  wire logic [TOL_W-1:0]   tolerance,
    input  wire logic [VALUE_W-1:0] prev_value,
    input  wire logic               far_flag,
    output logic      [VALUE_W-1:0] value_out,
    output logic                    flag_out
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               flag_reg;
    logic               flag_next;

    logic [VALUE_W:0]   diff_fw;
    logic [VALUE_W:0]   diff_bw;
    logic [VALUE_W:0]   magnitude;
    logic               in_span;
    logic               close_enough;

    // 33-bit differences in both directions; pick the non-negative one
    always_comb
    begin
        diff_fw      = {cmp_value[VALUE_W-1], cmp_value} - {value_reg[VALUE_W-1], value_reg};
        diff_bw      = {value_reg[VALUE_W-1], value_reg} - {cmp_value[VALUE_W-1], cmp_value};
        magnitude    = diff_fw[VALUE_W] ? diff_bw : diff_fw;
        close_enough = (magnitude <= {2'b00, tolerance});
        in_span      = (span > SPAN_W'(INDEX));
    end

    always_comb
    begin
        value_next = value_reg;
        flag_next  = flag_reg;
        if (ctrl.load)
        begin
            value_next = prev_value;
            flag_next  = in_span && close_enough;
        end
        else if (ctrl.scan)
        begin
            flag_next = far_flag;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        flag_reg  <= flag_next;
    end

    assign value_out = value_reg;
    assign flag_out  = flag_reg;

endmodule

`default_nettype wire

### rtl/near_duplicate_window_detect.sv
// near_duplicate_window_detect: top level, row of window cells plus control.
// Depends on ndwd_pkg, ndwd_if (ndwd_in_if, ndwd_out_if) and ndwd_cell.
`default_nettype none

//  channel   | dir | handshake         | payload
//  ----------+-----+-------------------+----------------------------------
//  items     | in  | valid/ready       | value (s32), first (1)
//  results   | out | valid/ready       | hit (1), found (1)
//  cfg       | in  | cfg_wr_en only    | cfg_index (1), cfg_data (31)
//
//  Span = min(window_k, WINDOW_DEPTH, values held in the sequence). The
//  transfer cycle compares the new value in every cell at once; the hit
//  flags then shift down the chain and are folded in eight per cycle, at
//  least one group per item, while the last group may wait for the output.
//  Reset clears control, fill count, found flag and config; cell values are
//  not reset, the fill count keeps unwritten cells out of the span.
//  A finished result waits in the output register while the next item is
//  taken; only the last scan cycle waits for a free output register.

module near_duplicate_window_detect import ndwd_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ndwd_in_if.sink                    items,
    ndwd_out_if.source                 results,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SPAN_W  = (FILL_W > WINDOW_K_W) ? FILL_W : WINDOW_K_W;
    localparam int GROUP_N = (SCAN_GROUP < WINDOW_DEPTH) ? SCAN_GROUP : WINDOW_DEPTH;

    // Config registers
    logic [WINDOW_K_W-1:0] window_k_reg;
    logic [WINDOW_K_W-1:0] window_k_next;
    logic [TOL_W-1:0]      tolerance_reg;
    logic [TOL_W-1:0]      tolerance_next;

    // Control state
    state_t              state_reg;
    state_t              state_next;
    logic [SPAN_W-1:0]   scan_left_reg;
    logic [SPAN_W-1:0]   scan_left_next;
    logic                acc_reg;
    logic                acc_next;
    logic [FILL_W-1:0]   fill_count_reg;
    logic [FILL_W-1:0]   fill_count_next;
    logic                found_flag_reg;
    logic                found_flag_next;

    // Output register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                res_hit_reg;
    logic                res_hit_next;
    logic                res_found_reg;
    logic                res_found_next;

    // Handshake and sequencing
    logic                in_xfer;
    logic                slot_free;
    logic                last_group;
    logic                step;
    logic                finish;
    logic                group_hit;
    logic                result_hit;

    // Span of the incoming item
    logic [FILL_W-1:0]   fill_base;
    logic [SPAN_W-1:0]   span_k;
    logic [SPAN_W-1:0]   span_kd;
    logic [SPAN_W-1:0]   span;
    logic [SPAN_W:0]     span_round;
    logic [SPAN_W-1:0]   span_groups;

    cell_ctrl_t          cell_ctrl;
    logic [VALUE_W-1:0]  cell_value [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] cell_flag;
    logic [WINDOW_DEPTH-1:0] cell_far;

    // ---------------- span of the new item ----------------
    always_comb
    begin
        fill_base   = items.first ? '0 : fill_count_reg;
        span_k      = SPAN_W'(window_k_reg);
        span_kd     = (span_k > SPAN_W'(WINDOW_DEPTH)) ? SPAN_W'(WINDOW_DEPTH) : span_k;
        span        = (span_kd > SPAN_W'(fill_base)) ? SPAN_W'(fill_base) : span_kd;
        // groups of eight flags to fold, at least one
        span_round  = {1'b0, span} + (SPAN_W + 1)'(SCAN_GROUP - 1);
        span_groups = SPAN_W'(span_round >> SCAN_GROUP_LOG);
        if (span_groups == '0)
        begin
            span_groups = SPAN_W'(1);
        end
    end

    // ---------------- sequencer ----------------
    assign slot_free  = !out_valid_reg || results.ready;
    assign last_group = (scan_left_reg == SPAN_W'(1));
    assign group_hit  = |cell_flag[GROUP_N-1:0];
    assign result_hit = acc_reg | group_hit;

    always_comb
    begin
        state_next  = state_reg;
        items.ready = 1'b0;
        step        = 1'b0;
        finish      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                items.ready = 1'b1;
                if (items.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // intermediate groups never wait; the last needs the output slot
                step   = !last_group || slot_free;
                finish = last_group && slot_free;
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_xfer        = items.valid && items.ready;
    assign cell_ctrl.load = in_xfer;
    assign cell_ctrl.scan = step;

    always_comb
    begin
        scan_left_next  = scan_left_reg;
        acc_next        = acc_reg;
        fill_count_next = fill_count_reg;
        found_flag_next = found_flag_reg;
        out_valid_next  = out_valid_reg;
        res_hit_next    = res_hit_reg;
        res_found_next  = res_found_reg;

        if (in_xfer)
        begin
            scan_left_next  = span_groups;
            acc_next        = 1'b0;
            fill_count_next = (fill_base < FILL_W'(WINDOW_DEPTH)) ?
                              fill_base + FILL_W'(1) : fill_base;
            if (items.first)
            begin
                found_flag_next = 1'b0;
            end
        end
        else if (step)
        begin
            scan_left_next = scan_left_reg - SPAN_W'(1);
            acc_next       = result_hit;
        end

        if (results.valid && results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (finish)
        begin
            out_valid_next  = 1'b1;
            res_hit_next    = result_hit;
            res_found_next  = found_flag_reg | result_hit;
            found_flag_next = found_flag_reg | result_hit;
        end
    end

    // ---------------- config port ----------------
    always_comb
    begin
        window_k_next  = window_k_reg;
        tolerance_next = tolerance_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_WINDOW_K:  window_k_next  = cfg_data[WINDOW_K_W-1:0];
                REG_TOLERANCE: tolerance_next = cfg_data[TOL_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_left_reg  <= '0;
            acc_reg        <= 1'b0;
            fill_count_reg <= '0;
            found_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            window_k_reg   <= '0;
            tolerance_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_left_reg  <= scan_left_next;
            acc_reg        <= acc_next;
            fill_count_reg <= fill_count_next;
            found_flag_reg <= found_flag_next;
            out_valid_reg  <= out_valid_next;
            window_k_reg   <= window_k_next;
            tolerance_reg  <= tolerance_next;
        end
    end

    // result payload: no reset needed
    always_ff @(posedge clk)
    begin
        res_hit_reg   <= res_hit_next;
        res_found_reg <= res_found_next;
    end

    assign results.valid = out_valid_reg;
    assign results.hit   = res_hit_reg;
    assign results.found = res_found_reg;

    // ---------------- window chain ----------------
    // cell 0 holds the newest value; flags shift toward cell 0 one group a cycle, except while the last group waits
    for (genvar j = 0; j < WINDOW_DEPTH; j++)
    begin : g_cell
        logic [VALUE_W-1:0] prev_value;

        if (j == 0)
        begin : g_head
            assign prev_value = items.value;
        end
        else
        begin : g_body
            assign prev_value = cell_value[j-1];
        end

        if (j + SCAN_GROUP < WINDOW_DEPTH)
        begin : g_far
            assign cell_far[j] = cell_flag[j+SCAN_GROUP];
        end
        else
        begin : g_tail
            assign cell_far[j] = 1'b0;
        end

        ndwd_cell #(
            .INDEX  (j),
            .SPAN_W (SPAN_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .span       (span),
            .cmp_value  (items.value),
            .tolerance  (tolerance_reg),
            .prev_value (prev_value),
            .far_flag   (cell_far[j]),
            .value_out  (cell_value[j]),
            .flag_out   (cell_flag[j])
        );
    end

    // ---------------- assertions ----------------
    a_found_covers_hit: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.hit |-> results.found)
        else $error("result hit without found");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_W'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    a_scan_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> scan_left_reg != '0)
        else $error("scan with no group left");

    a_xfer_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == ST_SCAN && !items.ready)
        else $error("item transfer did not start a scan");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> !out_valid_reg || results.ready)
        else $error("result loaded over a pending result");

endmodule

`default_nettype wire
